// ===== design/rfvc_pkg.sv =====
// Shared constants and types for the ring FIFO with value count.
// Used by the controller, the output stage, the top level and the checker.
package rfvc_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int DATA_W        = 32;

  // Operation codes carried on s_tuser.
  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_COUNT = 2'd2;

  // Result status codes carried on m_tuser.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Packed so that status sits in the lowest bits, then full, then empty.
  typedef struct packed {
    logic       empty_flag;
    logic       full_flag;
    logic [1:0] status;
  } flags_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    flags_t                   flags;
  } res_t;

endpackage

// ===== design/rfvc_mem.sv =====
// Slot storage: one write port and one read port, read data registered.
// Depends on nothing but its DEPTH and width parameters.
module rfvc_mem #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/rfvc_ctrl.sv =====
// Sequencer: head and occupancy registers, push/pop control and the match scan.
// Uses rfvc_pkg for codes and the result type; drives the slot memory ports.
module rfvc_ctrl #(
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH),
  localparam int OW   = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [1:0]                 s_mode,
  input  logic signed [rfvc_pkg::DATA_W-1:0] s_value,
  input  logic                       out_free,
  output logic                       res_load,
  output rfvc_pkg::res_t             res,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [rfvc_pkg::DATA_W-1:0] mem_wdata,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_raddr,
  input  logic [rfvc_pkg::DATA_W-1:0] mem_rdata
);

  localparam int SW = OW + 1;
  localparam logic [AW-1:0] IDX_LAST = AW'(DEPTH - 1);
  localparam logic [OW-1:0] OCC_FULL = OW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t        state, state_next;
  logic [AW-1:0] head, head_next;
  logic [OW-1:0] occ, occ_next;
  logic [AW-1:0] ptr, ptr_next;
  logic [OW-1:0] left, left_next;
  logic [OW-1:0] cnt, cnt_next;
  logic [rfvc_pkg::DATA_W-1:0] key, key_next;

  logic          accept;
  logic          is_full, is_empty;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail;
  logic [OW-1:0] cnt_sum;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
    return (idx == IDX_LAST) ? '0 : idx + AW'(1);
  endfunction

  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign is_full  = (occ == OCC_FULL);
  assign is_empty = (occ == '0);

  // head + occupancy stays below twice the depth, so one subtract wraps it.
  assign tail_sum = SW'(head) + SW'(occ);
  assign tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

  assign mem_waddr = tail;
  assign mem_wdata = s_value;
  assign cnt_sum   = cnt + OW'(mem_rdata == key);

  always_comb begin
    state_next = state;
    head_next  = head;
    occ_next   = occ;
    ptr_next   = ptr;
    left_next  = left;
    cnt_next   = cnt;
    key_next   = key;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = head;
    res_load   = 1'b0;
    res.data   = '0;
    res.flags.status = rfvc_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (s_mode)
            rfvc_pkg::MODE_PUSH: begin
              res_load = 1'b1;
              if (is_full) begin
                res.flags.status = rfvc_pkg::ST_FULL;
              end else begin
                mem_we   = 1'b1;
                occ_next = occ + OW'(1);
              end
            end
            rfvc_pkg::MODE_POP: begin
              if (is_empty) begin
                res_load         = 1'b1;
                res.data         = '1;
                res.flags.status = rfvc_pkg::ST_EMPTY;
              end else begin
                mem_re     = 1'b1;
                occ_next   = occ - OW'(1);
                // A drained queue restarts at slot zero.
                head_next  = (occ == OW'(1)) ? '0 : wrap_inc(head);
                state_next = S_POP;
              end
            end
            rfvc_pkg::MODE_COUNT: begin
              if (is_empty) begin
                res_load = 1'b1;
              end else begin
                mem_re     = 1'b1;
                ptr_next   = wrap_inc(head);
                left_next  = occ - OW'(1);
                cnt_next   = '0;
                key_next   = s_value;
                state_next = S_SCAN;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        res_load   = 1'b1;
        res.data   = mem_rdata;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        // Each cycle compares the word read last cycle and, while entries remain, issues the next read.
        if (left == '0) begin
          res_load   = 1'b1;
          res.data   = rfvc_pkg::DATA_W'(cnt_sum);
          state_next = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr;
          ptr_next  = wrap_inc(ptr);
          left_next = left - OW'(1);
          cnt_next  = cnt_sum;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    res.flags.full_flag  = (occ_next == OCC_FULL);
    res.flags.empty_flag = (occ_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      occ   <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      occ   <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr  <= ptr_next;
    left <= left_next;
    cnt  <= cnt_next;
    key  <= key_next;
  end

endmodule

// ===== design/rfvc_out.sv =====
// Output register stage that holds one result item until the sink takes it.
// Uses rfvc_pkg for the result type.
module rfvc_out (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  rfvc_pkg::res_t              res_in,
  output logic                        free,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [rfvc_pkg::DATA_W-1:0] m_tdata,
  output logic [3:0]                  m_tuser
);

  logic           valid, valid_next;
  rfvc_pkg::res_t res_q;

  assign free       = !valid || m_tready;
  assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

  assign m_tvalid = valid;
  assign m_tdata  = res_q.data;
  assign m_tuser  = res_q.flags;

endmodule

// ===== design/ring_fifo_with_value_count_top.sv =====
// Ring FIFO of signed 32-bit words with push, pop and match count operations.
// Instantiates rfvc_ctrl, rfvc_mem and rfvc_out; uses rfvc_pkg.
//
// Each input item carries an operation on s_tuser and a value on s_tdata and
// yields exactly one result item. Push, the unused code, and a pop or count on
// an empty queue finish in the accepting cycle; any other pop goes through a
// further state for the synchronous slot read, and a count scans the stored
// entries one per cycle through the single memory read port. No new item
// is taken while an operation is in progress; a finished result waits in an
// output register, and the next item is accepted as soon as that register is
// free or being drained. The slot memory needs no clearing after reset.
module ring_fifo_with_value_count_top #(
  parameter int DEPTH = rfvc_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [1:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] data
  output logic [3:0]  m_tuser    // [1:0] status, [2] full_flag, [3] empty_flag
);

  localparam int AW = $clog2(DEPTH);

  logic                        res_load;
  logic                        out_free;
  rfvc_pkg::res_t              res;
  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [rfvc_pkg::DATA_W-1:0] mem_wdata, mem_rdata;

  rfvc_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_mode    (s_tuser),
    .s_value   (s_tdata),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  rfvc_mem #(.DEPTH(DEPTH), .DATA_W(rfvc_pkg::DATA_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rfvc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_load),
    .res_in   (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== design/rfvc_checker.sv =====
// Port-level checks for the ring FIFO with value count, bound to the top level.
// Uses rfvc_pkg for the status codes.
module rfvc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [3:0]  m_tuser
);

  // A stalled result item holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result item changed while stalled");

  // The queue cannot be full and empty at once.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[2] && m_tuser[3]))
    else $error("full and empty flags both set");

  // A dropped push leaves the queue full and returns zero.
  a_drop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[1:0] == rfvc_pkg::ST_FULL) |-> m_tuser[2] && (m_tdata == '0))
    else $error("full status without full queue or nonzero data");

  // A pop on empty leaves the queue empty and returns all ones.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[1:0] == rfvc_pkg::ST_EMPTY) |-> m_tuser[3] && (m_tdata == '1))
    else $error("empty status without empty queue or wrong data");

  // While a result is stalled the block takes no new item.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while output register is blocked");

endmodule

bind ring_fifo_with_value_count_top rfvc_checker u_rfvc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for ring_fifo_with_value_count_top.
// Drives all four operation codes over the stream ports and checks each result item
// against a predictor of the ring FIFO. Depends on rfvc_pkg and the design files only.
`timescale 1ns / 100ps

module testbench;

  localparam int          FIFO_DEPTH  = rfvc_pkg::DEPTH_DEFAULT;
  localparam logic [1:0]  MODE_NOP    = 2'd3;
  localparam int          STALL_LIMIT = 2000;
  localparam int          HOLD_CYCLES = 200;

  typedef struct {
    logic signed [31:0] data;
    logic [1:0]         status;
    logic               full_flag;
    logic               empty_flag;
  } fifo_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] value
  logic [1:0]  s_tuser;   // [1:0] mode
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] data
  logic [3:0]  m_tuser;   // [1:0] status, [2] full_flag, [3] empty_flag

  // Predictor state.
  logic [31:0]  slot_store [FIFO_DEPTH];
  int           head_ptr;
  int           fill_level;
  fifo_result_t pending_results [$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int fail_cnt;

  ring_fifo_with_value_count_top #(.DEPTH(FIFO_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the result of one accepted item and updates the predicted queue.
  function automatic void apply_fifo_op(input logic [1:0] op, input logic [31:0] val);
    fifo_result_t r;
    int hits;
    int k;
    r.data   = '0;
    r.status = rfvc_pkg::ST_OK;
    hits     = 0;
    case (op)
      rfvc_pkg::MODE_PUSH: begin
        if (fill_level >= FIFO_DEPTH) begin
          r.status = rfvc_pkg::ST_FULL;
        end else begin
          slot_store[(head_ptr + fill_level) % FIFO_DEPTH] = val;
          fill_level++;
        end
      end
      rfvc_pkg::MODE_POP: begin
        if (fill_level == 0) begin
          r.data   = -32'sd1;
          r.status = rfvc_pkg::ST_EMPTY;
        end else begin
          r.data = slot_store[head_ptr];
          fill_level--;
          // A drained queue starts again from slot zero.
          head_ptr = (fill_level == 0) ? 0 : (head_ptr + 1) % FIFO_DEPTH;
        end
      end
      rfvc_pkg::MODE_COUNT: begin
        for (k = 0; k < fill_level; k++) begin
          if (slot_store[(head_ptr + k) % FIFO_DEPTH] == val) hits++;
        end
        r.data = hits;
      end
      default: ;
    endcase
    r.full_flag  = (fill_level >= FIFO_DEPTH);
    r.empty_flag = (fill_level == 0);
    pending_results.push_back(r);
  endfunction

  // Offers one item and returns at the rising edge that accepts it.
  // The handshake is decided at the falling edge, where all signals are settled.
  task automatic issue_op(input logic [1:0] op, input logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom();
      s_tuser  <= 2'($urandom());
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= val;
    do @(negedge clk); while (!s_tready);
    apply_fifo_op(op, val);
    @(posedge clk);
  endtask

  // Mostly a few small keys, so that counts find matches, plus the extremes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:             return 32'h8000_0000;
      1:             return 32'h7FFF_FFFF;
      2, 3, 4, 5, 6: return 32'($urandom_range(3)) - 32'd1;
      default:       return $urandom();
    endcase
  endfunction

  function automatic logic [1:0] pick_mixed_mode();
    int r;
    r = $urandom_range(99);
    if (r < 40) return rfvc_pkg::MODE_PUSH;
    if (r < 70) return rfvc_pkg::MODE_POP;
    if (r < 95) return rfvc_pkg::MODE_COUNT;
    return MODE_NOP;
  endfunction

  task automatic test_empty_ops();
    issue_op(rfvc_pkg::MODE_POP, 32'h1234_5678);
    issue_op(rfvc_pkg::MODE_COUNT, 32'h0000_0000);
    issue_op(MODE_NOP, 32'h0000_0000);
  endtask

  task automatic test_extreme_values();
    issue_op(rfvc_pkg::MODE_PUSH, 32'h8000_0000);
    issue_op(rfvc_pkg::MODE_PUSH, 32'h7FFF_FFFF);
    issue_op(rfvc_pkg::MODE_PUSH, 32'hFFFF_FFFF);
    issue_op(rfvc_pkg::MODE_PUSH, 32'h0000_0000);
    issue_op(rfvc_pkg::MODE_PUSH, 32'hFFFF_FFFF);
    issue_op(rfvc_pkg::MODE_COUNT, 32'hFFFF_FFFF);
    issue_op(rfvc_pkg::MODE_COUNT, 32'h8000_0000);
    issue_op(rfvc_pkg::MODE_COUNT, 32'h0000_3039);
    issue_op(MODE_NOP, 32'hFFFF_FFFF);
    repeat (5) issue_op(rfvc_pkg::MODE_POP, 32'hFFFF_FFFF);
    issue_op(rfvc_pkg::MODE_POP, 32'h0000_0000);
  endtask

  // After a drain the head restarts at zero; the order must still hold.
  task automatic test_drain_restart();
    issue_op(rfvc_pkg::MODE_PUSH, 32'h0000_0007);
    issue_op(rfvc_pkg::MODE_PUSH, 32'h0000_0008);
    issue_op(rfvc_pkg::MODE_POP, 32'h0);
    issue_op(rfvc_pkg::MODE_PUSH, 32'h0000_0009);
    issue_op(rfvc_pkg::MODE_COUNT, 32'h0000_0008);
    issue_op(rfvc_pkg::MODE_POP, 32'h0);
    issue_op(rfvc_pkg::MODE_POP, 32'h0);
  endtask

  // The receiver stops for a long stretch while items keep coming, then the
  // queue is filled past its depth, counted when full and wrapped around.
  task automatic test_backpressure_full();
    int i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    s_tvalid <= 1'b0;
    @(negedge clk);
    hold_req = HOLD_CYCLES;
    @(posedge clk);
    for (i = 0; i < FIFO_DEPTH + 1; i++) issue_op(rfvc_pkg::MODE_POP, $urandom());
    for (i = 0; i < FIFO_DEPTH + 2; i++) begin
      issue_op(rfvc_pkg::MODE_PUSH, (i % 3 == 0) ? 32'h5 : $urandom());
    end
    issue_op(rfvc_pkg::MODE_COUNT, 32'h5);
    for (i = 0; i < 5; i++) issue_op(rfvc_pkg::MODE_POP, 32'h0);
    for (i = 0; i < 6; i++) issue_op(rfvc_pkg::MODE_PUSH, 32'h5);
    issue_op(rfvc_pkg::MODE_COUNT, 32'h5);
    issue_op(rfvc_pkg::MODE_PUSH, 32'h7FFF_FFFF);
  endtask

  // Runs of pushes and pops drive the queue between empty and full, with
  // mixed stretches and counts in between.
  task automatic test_random_traffic(input int n_items, input int send_pct, input int recv_pct);
    int sent;
    int run_len;
    int i;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(3))
        0: begin
          run_len = $urandom_range(1, FIFO_DEPTH + 4);
          for (i = 0; i < run_len; i++) issue_op(rfvc_pkg::MODE_PUSH, pick_value());
        end
        1: begin
          run_len = $urandom_range(1, FIFO_DEPTH + 4);
          for (i = 0; i < run_len; i++) issue_op(rfvc_pkg::MODE_POP, $urandom());
        end
        2: begin
          run_len = $urandom_range(1, 12);
          for (i = 0; i < run_len; i++) issue_op(pick_mixed_mode(), pick_value());
        end
        default: begin
          run_len = $urandom_range(1, 4);
          for (i = 0; i < run_len; i++) issue_op(rfvc_pkg::MODE_COUNT, pick_value());
        end
      endcase
      sent += run_len;
    end
  endtask

  // Receiver: random ready, with a long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result checker: each accepted result item against the oldest prediction.
  initial begin
    fifo_result_t want;
    forever begin
      @(negedge clk);
      if (!rst && m_tvalid === 1'b1 && m_tready) begin
        if (pending_results.size() == 0) begin
          fail_cnt++;
          $error("result item with no prediction waiting: data %0d", $signed(m_tdata));
        end else begin
          want = pending_results.pop_front();
          if (m_tdata !== want.data) begin
            fail_cnt++;
            $error("data: expected %0d, got %0d", want.data, $signed(m_tdata));
          end
          if (m_tuser[1:0] !== want.status) begin
            fail_cnt++;
            $error("status: expected %0d, got %0d", want.status, m_tuser[1:0]);
          end
          if (m_tuser[2] !== want.full_flag) begin
            fail_cnt++;
            $error("full_flag: expected %0b, got %0b", want.full_flag, m_tuser[2]);
          end
          if (m_tuser[3] !== want.empty_flag) begin
            fail_cnt++;
            $error("empty_flag: expected %0b, got %0b", want.empty_flag, m_tuser[3]);
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no item moves on either side for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(negedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid === 1'b1 && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int i;
    fail_cnt      = 0;
    hold_req      = 0;
    head_ptr      = 0;
    fill_level    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (i = 0; i < FIFO_DEPTH; i++) slot_store[i] = '0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= rfvc_pkg::MODE_PUSH;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 31;
    recv_idle_pct = 64;
    test_empty_ops();
    test_extreme_values();
    test_drain_restart();
    test_backpressure_full();
    test_random_traffic(620, 31, 64);
    test_random_traffic(620, 64, 31);
    test_random_traffic(620, 0, 0);

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (FIFO_DEPTH + 5) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rfvc_pkg.sv
design/rfvc_mem.sv
design/rfvc_ctrl.sv
design/rfvc_out.sv
design/ring_fifo_with_value_count_top.sv
design/rfvc_checker.sv
tb/testbench.sv
